>>> rtl/core/assert_macros.svh
// Assertion macros used by the directory entry decoder cell module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger
`define ODED_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define ODED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/oded_pkg.sv
// Types, constants and functions shared by the directory entry decoder
package oded_pkg;

    localparam int unsigned NUM_LANES   = 4;
    localparam int unsigned LANE_NEXT   = 0;
    localparam int unsigned LANE_OFFSET = 1;
    localparam int unsigned LANE_SIZE   = 2;
    localparam int unsigned LANE_XOR    = 3;

    localparam int unsigned NUM_CELLS   = 8;
    localparam int unsigned DIGITS19    = 7;
    localparam int unsigned NAME_BYTES  = 6;
    localparam int unsigned PROD_W      = 65;

    localparam logic [29:0] MAGIC18  = 30'h38E3_8E39;
    localparam int unsigned SHIFT18  = 34;
    localparam logic [32:0] MAGIC19  = 33'h1_AF28_6BCB;
    localparam int unsigned SHIFT19  = 37;

    localparam logic [4:0]  BASE18       = 5'd18;
    localparam logic [4:0]  BASE19       = 5'd19;
    localparam logic [31:0] NIB18_LIMIT  = 32'hA;
    localparam logic [31:0] NIB19_LIMIT  = 32'd6;
    localparam logic [31:0] NIB19_BIAS   = 32'd9;
    localparam logic [31:0] NIB19_DROP   = 32'd8;
    localparam int unsigned SIZE_W       = 24;

    localparam logic [7:0]  CHAR_A       = 8'h41;
    localparam logic [7:0]  CHAR_N       = 8'h4E;
    localparam logic [7:0]  CHAR_SPACE   = 8'h20;
    localparam logic [7:0]  CHAR_END     = 8'h00;
    localparam logic [31:0] CODE_END     = 32'd14;
    localparam logic [31:0] CODE_SPACE   = 32'd28;
    localparam logic [31:0] OFS_LOW      = 32'd64;
    localparam logic [31:0] OFS_HIGH     = 32'd63;
    localparam logic [31:0] OFS_OTHER    = 32'd19;

    typedef struct packed {
        logic [31:0]                name_word;
        logic [31:0]                hash;
        logic                       ended;
        logic [NUM_LANES-1:0][31:0] rem;
        logic [NUM_LANES-1:0][31:0] acc;
    } t_cell_bus;

    function automatic logic [31:0] char_code(input logic [7:0] c);
        logic [31:0] cw;
        logic [31:0] code;
        cw = {24'd0, c};
        if (c >= CHAR_A && c < CHAR_N) begin
            code = cw - OFS_LOW;
        end else if (c == CHAR_END) begin
            code = CODE_END;
        end else if (c >= CHAR_N) begin
            code = cw - OFS_HIGH;
        end else if (c == CHAR_SPACE) begin
            code = CODE_SPACE;
        end else begin
            code = cw - OFS_OTHER;
        end
        return code;
    endfunction

endpackage

>>> rtl/core/oded_cell.sv
// One decode cell: a name hash step (if HASH_EN) and one digit of each word lane (size lane only below DIGITS19)
`include "assert_macros.svh"

module oded_cell #(
    parameter int unsigned DIGIT   = 0,
    parameter bit          HASH_EN = 1'b1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_char,
    input  logic                i_valid,
    input  oded_pkg::t_cell_bus i_bus,
    output logic                o_take,
    output logic                o_valid,
    output oded_pkg::t_cell_bus o_bus,
    input  logic                i_take
);

    localparam int unsigned SHIFT       = 4 * DIGIT;
    localparam bit          SIZE_ACTIVE = (DIGIT < oded_pkg::DIGITS19);

    logic                                                   r_a_valid;
    oded_pkg::t_cell_bus                                    r_a;
    logic [oded_pkg::NUM_LANES-1:0][oded_pkg::PROD_W-1:0]   r_a_prod;
    oded_pkg::t_cell_bus                                    n_a;
    logic [oded_pkg::NUM_LANES-1:0][oded_pkg::PROD_W-1:0]   n_a_prod;

    logic                r_b_valid;
    oded_pkg::t_cell_bus r_b;
    oded_pkg::t_cell_bus n_b;

    logic                              w_load_a;
    logic                              w_load_b;
    logic [oded_pkg::NUM_LANES-1:0]    w_rem_ok;

    assign w_load_b = !r_b_valid || i_take;
    assign w_load_a = !r_a_valid || w_load_b;
    assign o_take   = w_load_a;
    assign o_valid  = r_b_valid;
    assign o_bus    = r_b;

    always_comb begin
        logic       ended;
        logic [7:0] ch;
        n_a   = i_bus;
        ended = 1'b0;
        ch    = oded_pkg::CHAR_END;
        if (HASH_EN) begin
            ended    = i_bus.ended || (i_char == oded_pkg::CHAR_END);
            ch       = ended ? oded_pkg::CHAR_END : i_char;
            n_a.ended = ended;
            n_a.hash  = (i_bus.hash << 5) + (i_bus.hash << 3) + oded_pkg::char_code(ch);
        end
        for (int l = 0; l < oded_pkg::NUM_LANES; l++) begin
            if (l == oded_pkg::LANE_SIZE) begin
                n_a_prod[l] = oded_pkg::PROD_W'(i_bus.rem[l])
                            * oded_pkg::PROD_W'(oded_pkg::MAGIC19);
            end else begin
                n_a_prod[l] = oded_pkg::PROD_W'(i_bus.rem[l])
                            * oded_pkg::PROD_W'(oded_pkg::MAGIC18);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_load_a) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_a) begin
            r_a      <= n_a;
            r_a_prod <= n_a_prod;
        end
    end

    always_comb begin
        logic [31:0] q;
        logic [31:0] d;
        logic [31:0] t;
        n_b      = r_a;
        w_rem_ok = '1;
        for (int l = 0; l < oded_pkg::NUM_LANES; l++) begin
            if (l == oded_pkg::LANE_SIZE) begin
                q = 32'(r_a_prod[l] >> oded_pkg::SHIFT19);
                d = r_a.rem[l] - ((q << 4) + (q << 1) + q);
                if ((d - 32'd1) >= oded_pkg::NIB19_LIMIT) begin
                    t = d - oded_pkg::NIB19_DROP;
                end else begin
                    t = d + oded_pkg::NIB19_BIAS;
                end
                if (SIZE_ACTIVE) begin
                    w_rem_ok[l] = (d < 32'(oded_pkg::BASE19));
                    n_b.rem[l]  = q;
                    n_b.acc[l]  = r_a.acc[l] | (t << SHIFT);
                end
            end else begin
                q = 32'(r_a_prod[l] >> oded_pkg::SHIFT18);
                d = r_a.rem[l] - ((q << 4) + (q << 1));
                t = d - 32'd1;
                if (t >= oded_pkg::NIB18_LIMIT) begin
                    t = d - 32'd2;
                end
                w_rem_ok[l] = (d < 32'(oded_pkg::BASE18));
                n_b.rem[l]  = q;
                n_b.acc[l]  = r_a.acc[l] | (t << SHIFT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_load_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_b) begin
            r_b <= n_b;
        end
    end

    `ODED_ASSERT_IMPL(a_rem18_range, i_clk, i_rst_n, r_a_valid, w_rem_ok[oded_pkg::LANE_NEXT] && w_rem_ok[oded_pkg::LANE_OFFSET] && w_rem_ok[oded_pkg::LANE_XOR], "base-18 digit out of range")
    `ODED_ASSERT_IMPL(a_rem19_range, i_clk, i_rst_n, r_a_valid, w_rem_ok[oded_pkg::LANE_SIZE], "base-19 digit out of range")
    `ODED_ASSERT_NEXT(a_hold_b, i_clk, i_rst_n, r_b_valid && !i_take, r_b_valid && $stable(r_b), "stalled cell output changed")

endmodule

>>> rtl/core/obfuscated_dir_entry_decoder.sv
// Top level: directory entry decoder built from a row of digit cells
// Pipeline: 8 cells of 2 stages (A then B) each, then 1 output stage that drives o_valid.
// Throughput: one request per cycle while o_stall is low; each cell holds one digit divider per word lane.
// Requests are still taken while a finished result waits, as long as a stage is empty.
// Reset (i_rst_n low, synchronous) empties every stage and clears the lookup name to zero.
module obfuscated_dir_entry_decoder #(
    parameter int unsigned NAME_CHARS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [47:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_name_word,
    input  logic [31:0] i_offset_word,
    input  logic [31:0] i_size_word,
    input  logic [31:0] i_next_link_word,
    input  logic [31:0] i_xor_length_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_name_match,
    output logic [31:0] o_next_offset,
    output logic [31:0] o_file_offset,
    output logic [23:0] o_file_size,
    output logic [31:0] o_xor_bytes
);

    localparam int unsigned NC = oded_pkg::NUM_CELLS;

    logic [47:0]         r_lookup_name;
    oded_pkg::t_cell_bus w_bus   [NC+1];
    logic [NC:0]         w_valid;
    logic [NC:0]         w_take;

    logic        r_out_valid;
    logic        r_name_match;
    logic [31:0] r_next_offset;
    logic [31:0] r_file_offset;
    logic [23:0] r_file_size;
    logic [31:0] r_xor_bytes;
    logic        w_load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookup_name <= '0;
        end else if (i_cfg_wr_en) begin
            r_lookup_name <= i_cfg_wr_data;
        end
    end

    always_comb begin
        w_bus[0]                          = '0;
        w_bus[0].name_word                = i_name_word;
        w_bus[0].rem[oded_pkg::LANE_NEXT]   = i_next_link_word;
        w_bus[0].rem[oded_pkg::LANE_OFFSET] = i_offset_word;
        w_bus[0].rem[oded_pkg::LANE_SIZE]   = i_size_word;
        w_bus[0].rem[oded_pkg::LANE_XOR]    = i_xor_length_word;
    end

    assign w_valid[0] = i_valid;
    assign o_stall    = !w_take[0];

    for (genvar k = 0; k < NC; k++) begin : g_cell
        logic [7:0] w_char;
        if (k < oded_pkg::NAME_BYTES) begin : g_byte
            assign w_char = r_lookup_name[8*(oded_pkg::NAME_BYTES-1-k) +: 8];
        end else begin : g_nobyte
            assign w_char = oded_pkg::CHAR_END;
        end
        oded_cell #(
            .DIGIT   (k),
            .HASH_EN (k < NAME_CHARS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_char  (w_char),
            .i_valid (w_valid[k]),
            .i_bus   (w_bus[k]),
            .o_take  (w_take[k]),
            .o_valid (w_valid[k+1]),
            .o_bus   (w_bus[k+1]),
            .i_take  (w_take[k+1])
        );
    end

    assign w_load_out = !r_out_valid || !i_stall;
    assign w_take[NC] = w_load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= w_valid[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_name_match  <= (w_bus[NC].name_word == w_bus[NC].hash);
            r_next_offset <= w_bus[NC].acc[oded_pkg::LANE_NEXT];
            r_file_offset <= w_bus[NC].acc[oded_pkg::LANE_OFFSET];
            r_file_size   <= w_bus[NC].acc[oded_pkg::LANE_SIZE][oded_pkg::SIZE_W-1:0];
            r_xor_bytes   <= {w_bus[NC].acc[oded_pkg::LANE_XOR][29:0], 2'b00};
        end
    end

    assign o_valid       = r_out_valid;
    assign o_name_match  = r_name_match;
    assign o_next_offset = r_next_offset;
    assign o_file_offset = r_file_offset;
    assign o_file_size   = r_file_size;
    assign o_xor_bytes   = r_xor_bytes;

endmodule
